/* sv/scaw_pkg.sv */
package scaw_pkg;

  localparam int VALUE_W        = 48;
  localparam int FRAC_BITS      = 16;
  localparam int RANK_W         = 8;
  localparam int PROD_W         = 64;
  localparam int DIV_W          = 64;
  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEC_MAX        = 4;
  localparam int POW10_W        = 14;
  localparam int MUL_CNT_W      = $clog2(VALUE_W);
  localparam int DIV_CNT_W      = $clog2(DIV_W);

  localparam logic [RANK_W-1:0] RANK_CMP = {RANK_W{1'b1}};

  localparam logic [POW10_W-1:0] POW10 [DEC_MAX+1] = '{
    14'd1, 14'd10, 14'd100, 14'd1000, 14'd10000
  };

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_MOD     = 4'd4,
    OP_MAX     = 4'd5,
    OP_MIN     = 4'd6,
    OP_REACH   = 4'd7,
    OP_NREACH  = 4'd8,
    OP_WINMAX  = 4'd9,
    OP_WINMIN  = 4'd10,
    OP_WINMEAN = 4'd11,
    OP_ARRMAX  = 4'd12,
    OP_ARRMIN  = 4'd13,
    OP_TRUNC   = 4'd14,
    OP_ROUND   = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_MUL,
    S_DEC,
    S_DGO,
    S_DIV,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* sv/scaw_cell.sv */
module scaw_cell import scaw_pkg::*; #(
  parameter int W = VALUE_W
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

/* sv/scaw_mul.sv */
module scaw_mul import scaw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [VALUE_W-1:0] a,
  input  logic signed [VALUE_W-1:0] b,
  output unit_stat_t                stat,
  output logic [PROD_W-1:0]         prod
);

  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic [PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [VALUE_W-1:0]   mplier_r, mplier_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [PROD_W-1:0]    addend;
  logic                 last_step;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    addend     = mplier_r[0] ? mcand_r : '0;
    last_step  = cnt_r == MUL_CNT_W'(VALUE_W - 1);
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = PROD_W'(a);
      mplier_nxt = b;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      // top bit of the multiplier carries negative weight
      acc_nxt    = last_step ? acc_r - addend : acc_r + addend;
      mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[VALUE_W-1:1]};
      cnt_nxt    = cnt_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

/* sv/scaw_div.sv */
module scaw_div import scaw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [VALUE_W-1:0] divisor,
  output unit_stat_t         stat,
  output logic [DIV_W-1:0]   quot,
  output logic [VALUE_W-1:0] rem
);

  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [VALUE_W-1:0]   rem_r, rem_nxt;
  logic [VALUE_W-1:0]   dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [VALUE_W:0]     trial;
  logic                 ge;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[DIV_W-1]};
    ge       = trial >= {1'b0, dsr_r};
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // quotient bits fill the dividend register from below
      rem_nxt = ge ? VALUE_W'(trial - {1'b0, dsr_r}) : VALUE_W'(trial);
      dvd_nxt = {dvd_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = dvd_r;
  assign rem       = rem_r;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");
`endif

endmodule

/* sv/sample_constant_arith_window.sv */
// sample-against-constant arithmetic with sliding window and array extremes
// in_*  : input words; tdata = sample_value, sample_rank; tuser = cmd; tlast = end of array
// out_* : result words; tdata = result_value, result_rank; tlast = result_last
// cfg_* : register port; operation at byte 0, constant_value at byte 8 (64-bit data)
// one word is in flight at a time; in_tready is high while the block is idle
// path per word, acceptance to result register:
//   add, sub, max, min, reaches: the operation state, then the finish state
//   array extremes: the same, but only the last word of an array gives a result;
//   mul: the bit-serial multiplier (one multiplier bit a cycle)
//   div, mod: the one-bit-a-cycle divider; trunc, round: scaling, then the divider
//   (div and mod with a zero constant, and trunc and round below zero, skip the divider)
//   window max and min: one full rotation of the cell chain; window mean: rotation followed by the divider
// a seam-start word is taken and gives no result
// the result register frees the input side: a new word is taken while a result waits;
// when the receiver stalls with a result still held, the next result waits in place
// reset clears the window count, the array extreme and the registers (to zero)
module sample_constant_arith_window import scaw_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [55:0]               in_tdata,   // sample_value[47:0], sample_rank[55:48]
  input  logic                      in_tuser,   // cmd
  input  logic                      in_tlast,   // last_in_array
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [55:0]               out_tdata,  // result_value[47:0], result_rank[55:48]
  output logic                      out_tlast,  // result_last
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [3:0]                cfg_paddr,
  input  logic [63:0]               cfg_pwdata,
  output logic [63:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int SUM_W = VALUE_W + IDX_W + 1;
  localparam int NUM_W = FRAC_BITS + POW10_W + 1;
  localparam int K_W   = POW10_W + 1;
  localparam int INT_W = VALUE_W - FRAC_BITS;

  // registers
  op_t                       op_r;
  logic signed [VALUE_W-1:0] const_r;

  // input word
  logic signed [VALUE_W-1:0] a_r, a_nxt;
  logic [RANK_W-1:0]         rank_r, rank_nxt;
  logic                      last_r, last_nxt;

  // control and working state
  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          win_count_r, win_count_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [IDX_W-1:0]          scan_idx_r, scan_idx_nxt;
  logic signed [VALUE_W-1:0] ext_r, ext_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [VALUE_W-1:0] best_value_r, best_value_nxt;
  logic [RANK_W-1:0]         best_rank_r, best_rank_nxt;
  logic                      best_valid_r, best_valid_nxt;
  logic [DIV_W-1:0]          dvd_r, dvd_nxt;
  logic [VALUE_W-1:0]        dsr_r, dsr_nxt;
  logic [VALUE_W-1:0]        res_r, res_nxt;
  logic [RANK_W-1:0]         rres_r, rres_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]        out_value_r, out_value_nxt;
  logic [RANK_W-1:0]         out_rank_r, out_rank_nxt;
  logic                      out_last_r, out_last_nxt;

  // cell chain
  logic [VALUE_W-1:0]        cell_q [MAX_WINDOW];
  logic [VALUE_W-1:0]        cell_d [MAX_WINDOW];
  logic [VALUE_W-1:0]        head_d;
  logic                      shift_en;

  // multiplier and shared divider
  logic                      mul_start, div_start;
  unit_stat_t                mul_stat, div_stat;
  logic [PROD_W-1:0]         prod;
  logic [DIV_W-1:0]          quot;
  logic [VALUE_W-1:0]        drem;

  // datapath helpers
  logic                      in_acc, cfg_wr;
  logic                      a_neg, c_neg, s_neg;
  logic [VALUE_W-1:0]        a_mag, c_mag, c_int_max;
  logic [INT_W-1:0]          c_int;
  logic [CNT_W-1:0]          keep;
  logic [2:0]                dsel;
  logic [POW10_W-1:0]        p;
  logic [NUM_W-1:0]          num;
  logic [K_W-1:0]            k;
  logic [SUM_W-1:0]          s_mag;
  logic signed [VALUE_W-1:0] v;
  logic                      v_in;
  logic                      upd;
  logic [VALUE_W-1:0]        fr_sum, q_adj;

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = state_r == S_IDLE;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[3] ? {{(64-VALUE_W){const_r[VALUE_W-1]}}, const_r}
                                   : {60'd0, op_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_ADD;
      const_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[3]) begin
        const_r <= cfg_pwdata[VALUE_W-1:0];
      end else begin
        op_r <= op_t'(cfg_pwdata[3:0]);
      end
    end
  end

  // chain: cell 0 holds the newest sample; rotation brings every cell past cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_d[i] = head_d;
    end else begin : g_body
      assign cell_d[i] = cell_q[i-1];
    end
    scaw_cell #(.W(VALUE_W)) u_cell (
      .clk (clk),
      .en  (shift_en),
      .d   (cell_d[i]),
      .q   (cell_q[i])
    );
  end

  scaw_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (a_r),
    .b     (const_r),
    .stat  (mul_stat),
    .prod  (prod)
  );

  scaw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (dsr_r),
    .stat     (div_stat),
    .quot     (quot),
    .rem      (drem)
  );

  always_comb begin
    a_neg     = a_r[VALUE_W-1];
    c_neg     = const_r[VALUE_W-1];
    s_neg     = sum_r[SUM_W-1];
    a_mag     = a_neg ? VALUE_W'(-a_r) : VALUE_W'(a_r);
    c_mag     = c_neg ? VALUE_W'(-const_r) : VALUE_W'(const_r);
    s_mag     = s_neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    c_int     = const_r[VALUE_W-1:FRAC_BITS];
    c_int_max = VALUE_W'(MAX_WINDOW - 1);
    if (c_neg) begin
      keep = '0;
    end else if (VALUE_W'(c_int) >= c_int_max) begin
      keep = CNT_W'(MAX_WINDOW - 1);
    end else begin
      keep = CNT_W'(c_int);
    end
    dsel  = (c_int > INT_W'(DEC_MAX)) ? 3'(DEC_MAX) : c_int[2:0];
    p     = POW10[dsel];
    num   = NUM_W'(a_mag[FRAC_BITS-1:0]) * NUM_W'(p);
    k     = (op_r == OP_ROUND)
            ? K_W'((num + NUM_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS)
            : K_W'(num >> FRAC_BITS);
    v     = cell_q[0];
    // step 0 sees the newest sample, step s the one that is MAX_WINDOW - s old
    v_in  = (scan_idx_r == '0) ||
            ((CNT_W'(MAX_WINDOW) - CNT_W'(scan_idx_r)) < n_r);
    upd   = !best_valid_r ||
            ((op_r == OP_ARRMAX) ? (a_r > best_value_r) : (a_r < best_value_r));
    fr_sum = {a_mag[VALUE_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}} + quot[VALUE_W-1:0];
    q_adj  = quot[VALUE_W-1:0] + VALUE_W'(s_neg && (drem != '0));
  end

  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    rank_nxt       = rank_r;
    last_nxt       = last_r;
    win_count_nxt  = win_count_r;
    n_nxt          = n_r;
    scan_idx_nxt   = scan_idx_r;
    ext_nxt        = ext_r;
    sum_nxt        = sum_r;
    best_value_nxt = best_value_r;
    best_rank_nxt  = best_rank_r;
    best_valid_nxt = best_valid_r;
    dvd_nxt        = dvd_r;
    dsr_nxt        = dsr_r;
    res_nxt        = res_r;
    rres_nxt       = rres_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_rank_nxt   = out_rank_r;
    out_last_nxt   = out_last_r;
    head_d         = cell_q[MAX_WINDOW-1];
    shift_en       = 1'b0;
    mul_start      = 1'b0;
    div_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            win_count_nxt  = '0;
            best_valid_nxt = 1'b0;
          end else begin
            a_nxt     = in_tdata[VALUE_W-1:0];
            rank_nxt  = in_tdata[VALUE_W +: RANK_W];
            last_nxt  = in_tlast;
            state_nxt = S_OP;
          end
        end
      end
      S_OP: begin
        rres_nxt  = rank_r;
        state_nxt = S_FIN;
        unique case (op_r) inside
          OP_ADD:    res_nxt = VALUE_W'(a_r + const_r);
          OP_SUB:    res_nxt = VALUE_W'(a_r - const_r);
          OP_MAX:    res_nxt = (a_r > const_r) ? a_r : const_r;
          OP_MIN:    res_nxt = (a_r < const_r) ? a_r : const_r;
          OP_REACH: begin
            res_nxt  = (a_r >= const_r) ? VALUE_W'(1 << FRAC_BITS) : '0;
            rres_nxt = RANK_CMP;
          end
          OP_NREACH: begin
            res_nxt  = (a_r < const_r) ? VALUE_W'(1 << FRAC_BITS) : '0;
            rres_nxt = RANK_CMP;
          end
          OP_MUL: begin
            mul_start = 1'b1;
            state_nxt = S_MUL;
          end
          OP_DIV, OP_MOD: begin
            if (const_r == '0) begin
              res_nxt = '0;
            end else begin
              dvd_nxt   = (op_r == OP_DIV) ? (DIV_W'(a_mag) << FRAC_BITS) : DIV_W'(a_mag);
              dsr_nxt   = c_mag;
              state_nxt = S_DGO;
            end
          end
          OP_TRUNC, OP_ROUND: begin
            if (c_neg) begin
              res_nxt = a_r;
            end else begin
              state_nxt = S_DEC;
            end
          end
          OP_WINMAX, OP_WINMIN, OP_WINMEAN: begin
            head_d       = a_r;
            shift_en     = 1'b1;
            n_nxt        = win_count_r + 1'b1;
            ext_nxt      = a_r;
            sum_nxt      = '0;
            scan_idx_nxt = '0;
            state_nxt    = S_SCAN;
          end
          OP_ARRMAX, OP_ARRMIN: begin
            if (upd) begin
              best_value_nxt = a_r;
              best_rank_nxt  = rank_r;
            end
            best_valid_nxt = 1'b1;
            res_nxt        = upd ? a_r : best_value_r;
            rres_nxt       = upd ? rank_r : best_rank_r;
            if (last_r) begin
              best_valid_nxt = 1'b0;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_MUL: begin
        if (mul_stat.done) begin
          res_nxt   = prod[FRAC_BITS +: VALUE_W];
          state_nxt = S_FIN;
        end
      end
      S_DEC: begin
        dvd_nxt   = (DIV_W'(k) << FRAC_BITS) + DIV_W'(p >> 1);
        dsr_nxt   = VALUE_W'(p);
        state_nxt = S_DGO;
      end
      S_DGO: begin
        if (op_r == OP_WINMEAN) begin
          dvd_nxt = DIV_W'(s_mag);
          dsr_nxt = VALUE_W'(n_r);
        end
        div_start = op_r != OP_WINMEAN;
        if (op_r == OP_WINMEAN) begin
          state_nxt = S_DGO;
          // operands land this cycle; start on the next pass
          if (dvd_r == DIV_W'(s_mag) && dsr_r == VALUE_W'(n_r)) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_FIN;
          case (op_r)
            OP_DIV:     res_nxt = (a_neg ^ c_neg) ? VALUE_W'(-quot[VALUE_W-1:0])
                                                  : quot[VALUE_W-1:0];
            OP_MOD:     res_nxt = a_neg ? VALUE_W'(-drem) : drem;
            OP_WINMEAN: res_nxt = s_neg ? VALUE_W'(-q_adj) : q_adj;
            default:    res_nxt = a_neg ? VALUE_W'(-fr_sum) : fr_sum;
          endcase
        end
      end
      S_SCAN: begin
        shift_en     = 1'b1;
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (v_in) begin
          if (op_r == OP_WINMAX && v > ext_r) begin
            ext_nxt = v;
          end
          if (op_r == OP_WINMIN && v < ext_r) begin
            ext_nxt = v;
          end
          sum_nxt = sum_r + SUM_W'(v);
        end
        if (scan_idx_r == IDX_W'(MAX_WINDOW - 1)) begin
          scan_idx_nxt  = '0;
          win_count_nxt = (n_r < keep) ? n_r : keep;
          if (op_r == OP_WINMEAN) begin
            state_nxt = S_DGO;
          end else begin
            res_nxt   = ext_nxt;
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_rank_nxt  = rres_r;
          out_last_nxt  = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_count_r  <= '0;
      scan_idx_r   <= '0;
      best_valid_r <= 1'b0;
      best_value_r <= '0;
      best_rank_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      win_count_r  <= win_count_nxt;
      scan_idx_r   <= scan_idx_nxt;
      best_valid_r <= best_valid_nxt;
      best_value_r <= best_value_nxt;
      best_rank_r  <= best_rank_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    rank_r      <= rank_nxt;
    last_r      <= last_nxt;
    n_r         <= n_nxt;
    ext_r       <= ext_nxt;
    sum_r       <= sum_nxt;
    dvd_r       <= dvd_nxt;
    dsr_r       <= dsr_nxt;
    res_r       <= res_nxt;
    rres_r      <= rres_nxt;
    out_value_r <= out_value_nxt;
    out_rank_r  <= out_rank_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rank_r, out_value_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    win_count_r <= CNT_W'(MAX_WINDOW - 1))
    else $error("window count beyond window length");
  a_seam_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (win_count_r == '0 && !best_valid_r))
    else $error("seam start left window or extreme state");
  a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> (scan_idx_r == '0))
    else $error("scan index not parked outside a scan");
`endif

endmodule
